/* hdl/bis_pkg.sv */
`default_nettype none
package bis_pkg;

   localparam int RECORDS_DEFAULT  = 128;
   localparam int BLOCKS_DEFAULT   = 32;
   localparam int KEY_BITS_DEFAULT = 32;

   localparam int CMD_BITS      = 2;
   localparam int SLOT_BITS     = 7;
   localparam int SCAN_BITS     = SLOT_BITS + 1;
   localparam int KEY_PORT_BITS = 32;
   localparam int EXT_BITS      = 64;
   localparam int COUNT_BITS    = 6;

   localparam logic [COUNT_BITS-1:0] COUNT_RESET = COUNT_BITS'(1);

   localparam logic [CMD_BITS-1:0] CMD_WRITE_RECORD = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_WRITE_INDEX  = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_SEARCH       = 2'd2;

   typedef struct packed {
      logic write_record;
      logic write_index;
      logic load_search;
      logic read_mid;
      logic step_search;
      logic read_block;
      logic load_block;
      logic read_record;
      logic next_record;
      logic hit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic range_open;
      logic key_below;
      logic key_above;
      logic block_valid;
      logic scan_open;
      logic key_match;
   } ctrl_status_type;

endpackage
`default_nettype wire

/* hdl/block_indexed_search.sv */
// channel   ports                                              handshake
// req       req_command req_slot req_key req_block_start/end   start & !busy
// rsp       rsp_found rsp_position                             rsp_valid, one cycle
// csr       csr_block_count                                    csr_valid & csr_ready
//
// writes complete in the idle state; busy stays low and no rsp beat follows
// a search probes the index, then scans the chosen block's records; every read
// uses the single read port of the index and record RAMs (registered read)
// reset is synchronous; block count returns to 1, the RAMs hold no reset value
// rsp_valid is high one cycle and cannot be held off; busy drops the cycle after
`default_nettype none
module block_indexed_search #(
   parameter int RECORDS  = bis_pkg::RECORDS_DEFAULT,
   parameter int BLOCKS   = bis_pkg::BLOCKS_DEFAULT,
   parameter int KEY_BITS = bis_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     start,
   output logic                                          busy,
   input  wire logic        [bis_pkg::CMD_BITS-1:0]      req_command,
   input  wire logic        [bis_pkg::SLOT_BITS-1:0]     req_slot,
   input  wire logic signed [bis_pkg::KEY_PORT_BITS-1:0] req_key,
   input  wire logic        [bis_pkg::SLOT_BITS-1:0]     req_block_start,
   input  wire logic        [bis_pkg::SLOT_BITS-1:0]     req_block_end,
   output logic                                          rsp_valid,
   output logic                                          rsp_found,
   output logic             [bis_pkg::SLOT_BITS-1:0]     rsp_position,
   input  wire logic                                     csr_valid,
   output logic                                          csr_ready,
   input  wire logic        [bis_pkg::COUNT_BITS-1:0]    csr_block_count
);

   bis_pkg::ctrl_cmd_type    cmd;
   bis_pkg::ctrl_status_type status;

   assign csr_ready = !busy;

   bis_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_command),
      .status  (status),
      .cmd     (cmd),
      .busy    (busy),
      .done    (rsp_valid)
   );

   bis_dpath #(
      .RECORDS  (RECORDS),
      .BLOCKS   (BLOCKS),
      .KEY_BITS (KEY_BITS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_valid && csr_ready),
      .csr_block_count (csr_block_count),
      .req_slot        (req_slot),
      .req_key         (req_key),
      .req_block_start (req_block_start),
      .req_block_end   (req_block_end),
      .cmd             (cmd),
      .status          (status),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position)
   );

endmodule
`default_nettype wire

/* hdl/bis_ram.sv */
`default_nettype none
module bis_ram #(
   parameter int WIDTH     = 8,
   parameter int DEPTH     = 2,
   parameter int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_BITS-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]     wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_BITS-1:0] rd_addr,
   output logic      [WIDTH-1:0]     rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* hdl/bis_ctrl.sv */
`default_nettype none
module bis_ctrl (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   input  wire logic [bis_pkg::CMD_BITS-1:0] command,
   input  wire bis_pkg::ctrl_status_type     status,
   output bis_pkg::ctrl_cmd_type             cmd,
   output logic                              busy,
   output logic                              done
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_MID    = 3'd1;
   localparam logic [2:0] S_CMP    = 3'd2;
   localparam logic [2:0] S_BLOCK  = 3'd3;
   localparam logic [2:0] S_BOUNDS = 3'd4;
   localparam logic [2:0] S_SCAN   = 3'd5;
   localparam logic [2:0] S_TEST   = 3'd6;
   localparam logic [2:0] S_DONE   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               unique case (command)
                  bis_pkg::CMD_WRITE_RECORD: cmd.write_record = 1'b1;
                  bis_pkg::CMD_WRITE_INDEX:  cmd.write_index  = 1'b1;
                  bis_pkg::CMD_SEARCH: begin
                     cmd.load_search = 1'b1;
                     state_in        = S_MID;
                  end
                  default: ;
               endcase
            end
         end
         S_MID: begin
            if (status.range_open) begin
               cmd.read_mid = 1'b1;
               state_in     = S_CMP;
            end else begin
               state_in = S_BLOCK;
            end
         end
         S_CMP: begin
            cmd.step_search = 1'b1;
            if (!status.key_below && !status.key_above) begin
               state_in = S_BLOCK;
            end else begin
               state_in = S_MID;
            end
         end
         S_BLOCK: begin
            if (status.block_valid) begin
               cmd.read_block = 1'b1;
               state_in       = S_BOUNDS;
            end else begin
               state_in = S_DONE;
            end
         end
         S_BOUNDS: begin
            cmd.load_block = 1'b1;
            state_in       = S_SCAN;
         end
         S_SCAN: begin
            if (status.scan_open) begin
               cmd.read_record = 1'b1;
               state_in        = S_TEST;
            end else begin
               state_in = S_DONE;
            end
         end
         S_TEST: begin
            if (status.key_match) begin
               cmd.hit  = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.next_record = 1'b1;
               state_in        = S_SCAN;
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != S_IDLE);
   assign done = (state_ff == S_DONE);

endmodule
`default_nettype wire

/* hdl/bis_dpath.sv */
`default_nettype none
module bis_dpath #(
   parameter int RECORDS  = bis_pkg::RECORDS_DEFAULT,
   parameter int BLOCKS   = bis_pkg::BLOCKS_DEFAULT,
   parameter int KEY_BITS = bis_pkg::KEY_BITS_DEFAULT
) (
   input  wire logic                                    clock,
   input  wire logic                                    reset,
   input  wire logic                                    csr_we,
   input  wire logic        [bis_pkg::COUNT_BITS-1:0]   csr_block_count,
   input  wire logic        [bis_pkg::SLOT_BITS-1:0]    req_slot,
   input  wire logic signed [bis_pkg::KEY_PORT_BITS-1:0] req_key,
   input  wire logic        [bis_pkg::SLOT_BITS-1:0]    req_block_start,
   input  wire logic        [bis_pkg::SLOT_BITS-1:0]    req_block_end,
   input  wire bis_pkg::ctrl_cmd_type                   cmd,
   output bis_pkg::ctrl_status_type                     status,
   output logic                                         rsp_found,
   output logic             [bis_pkg::SLOT_BITS-1:0]    rsp_position
);

   localparam int RW       = (RECORDS > 1) ? $clog2(RECORDS) : 1;
   localparam int IW       = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int CW       = $clog2(BLOCKS + 1);
   localparam int SB       = bis_pkg::SLOT_BITS;
   localparam int IDX_BITS = KEY_BITS + 2 * SB;

   logic [bis_pkg::COUNT_BITS-1:0] count_ff;
   logic signed [KEY_BITS-1:0]     key_ff;
   logic [CW-1:0]                  lo_ff;
   logic [CW-1:0]                  lo_in;
   logic [CW-1:0]                  hi_ff;
   logic [CW-1:0]                  hi_in;
   logic [bis_pkg::SCAN_BITS-1:0]  p_ff;
   logic [bis_pkg::SCAN_BITS-1:0]  p_in;
   logic [SB-1:0]                  end_ff;
   logic                           found_ff;
   logic [SB-1:0]                  pos_ff;

   logic [bis_pkg::EXT_BITS-1:0]   key_ext;
   logic signed [KEY_BITS-1:0]     key_cut;
   logic [CW-1:0]                  count_sat;
   logic [CW:0]                    mid_sum;
   logic [CW-1:0]                  mid_full;
   logic [RW+SB-1:0]               rec_slot_wide;
   logic [IW+SB-1:0]               idx_slot_wide;
   logic [RW+bis_pkg::SCAN_BITS-1:0] p_wide;

   logic              rec_wr_en;
   logic [RW-1:0]     rec_rd_addr;
   logic [KEY_BITS-1:0] rec_rd_data;
   logic              idx_wr_en;
   logic              idx_rd_en;
   logic [IW-1:0]     idx_rd_addr;
   logic [IDX_BITS-1:0] idx_wr_data;
   logic [IDX_BITS-1:0] idx_rd_data;
   logic signed [KEY_BITS-1:0] idx_max;
   logic [SB-1:0]     idx_start;
   logic [SB-1:0]     idx_end;

   assign key_ext = {{(bis_pkg::EXT_BITS - bis_pkg::KEY_PORT_BITS)
                      {req_key[bis_pkg::KEY_PORT_BITS-1]}}, req_key};
   assign key_cut = key_ext[KEY_BITS-1:0];

   assign count_sat = (32'(count_ff) > 32'(BLOCKS)) ? CW'(BLOCKS) : CW'(count_ff);

   assign mid_sum  = {1'b0, lo_ff} + {1'b0, hi_ff} - (CW+1)'(1);
   assign mid_full = mid_sum[CW:1];

   assign rec_slot_wide = (RW+SB)'(req_slot);
   assign idx_slot_wide = (IW+SB)'(req_slot);
   assign p_wide        = (RW+bis_pkg::SCAN_BITS)'(p_ff);

   assign rec_wr_en   = cmd.write_record && (32'(req_slot) < 32'(RECORDS));
   assign rec_rd_addr = p_wide[RW-1:0];

   assign idx_wr_en   = cmd.write_index && (32'(req_slot) < 32'(BLOCKS));
   assign idx_wr_data = {key_cut, req_block_start, req_block_end};
   assign idx_rd_en   = cmd.read_mid || cmd.read_block;
   assign idx_rd_addr = cmd.read_block ? hi_ff[IW-1:0] : mid_full[IW-1:0];

   assign idx_max   = idx_rd_data[IDX_BITS-1 -: KEY_BITS];
   assign idx_start = idx_rd_data[2*SB-1:SB];
   assign idx_end   = idx_rd_data[SB-1:0];

   bis_ram #(
      .WIDTH (KEY_BITS),
      .DEPTH (RECORDS)
   ) u_record_ram (
      .clock   (clock),
      .wr_en   (rec_wr_en),
      .wr_addr (rec_slot_wide[RW-1:0]),
      .wr_data (key_cut),
      .rd_en   (cmd.read_record),
      .rd_addr (rec_rd_addr),
      .rd_data (rec_rd_data)
   );

   bis_ram #(
      .WIDTH (IDX_BITS),
      .DEPTH (BLOCKS)
   ) u_index_ram (
      .clock   (clock),
      .wr_en   (idx_wr_en),
      .wr_addr (idx_slot_wide[IW-1:0]),
      .wr_data (idx_wr_data),
      .rd_en   (idx_rd_en),
      .rd_addr (idx_rd_addr),
      .rd_data (idx_rd_data)
   );

   always_comb begin
      lo_in = lo_ff;
      hi_in = hi_ff;
      p_in  = p_ff;
      priority if (cmd.load_search) begin
         lo_in = '0;
         hi_in = count_sat;
      end else if (cmd.step_search) begin
         if (status.key_above) begin
            lo_in = mid_full + CW'(1);
         end else begin
            hi_in = mid_full;
         end
      end else if (cmd.load_block) begin
         p_in = bis_pkg::SCAN_BITS'(idx_start);
      end else if (cmd.next_record) begin
         p_in = p_ff + bis_pkg::SCAN_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= bis_pkg::COUNT_RESET;
      end else if (csr_we) begin
         count_ff <= csr_block_count;
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      p_ff  <= p_in;
      if (cmd.load_search) begin
         key_ff   <= key_cut;
         found_ff <= 1'b0;
         pos_ff   <= '0;
      end
      if (cmd.load_block) begin
         end_ff <= idx_end;
      end
      if (cmd.hit) begin
         found_ff <= 1'b1;
         pos_ff   <= p_ff[SB-1:0];
      end
   end

   assign status.range_open  = (lo_ff < hi_ff);
   assign status.key_below   = (key_ff < idx_max);
   assign status.key_above   = (key_ff > idx_max);
   assign status.block_valid = (hi_ff < count_sat);
   assign status.scan_open   = (p_ff <= bis_pkg::SCAN_BITS'(end_ff))
                               && (32'(p_ff) < 32'(RECORDS));
   assign status.key_match   = (rec_rd_data == $unsigned(key_ff));

   assign rsp_found    = found_ff;
   assign rsp_position = pos_ff;

endmodule
`default_nettype wire

/* hdl/bis_check.sv */
`default_nettype none
module bis_check (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           start,
   input wire logic                           busy,
   input wire logic [bis_pkg::CMD_BITS-1:0]   req_command,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_found,
   input wire logic [bis_pkg::SLOT_BITS-1:0]  rsp_position
);

   a_rsp_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("rsp beat outside a search");

   a_miss_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> rsp_position == '0)
      else $error("miss with nonzero position");

   a_search_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command == bis_pkg::CMD_SEARCH |=> busy)
      else $error("search beat did not raise busy");

   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_command != bis_pkg::CMD_SEARCH |=> !busy && !rsp_valid)
      else $error("write beat left the block busy or gave a rsp beat");

   a_rsp_release: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy && !rsp_valid)
      else $error("busy held after rsp beat");

endmodule

bind block_indexed_search bis_check u_bis_check (.*);
`default_nettype wire

/* dv/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RECORDS = bis_pkg::RECORDS_DEFAULT;
   localparam int BLOCKS  = bis_pkg::BLOCKS_DEFAULT;
   localparam int CMD_BITS      = bis_pkg::CMD_BITS;
   localparam int SLOT_BITS     = bis_pkg::SLOT_BITS;
   localparam int KEY_PORT_BITS = bis_pkg::KEY_PORT_BITS;
   localparam int COUNT_BITS    = bis_pkg::COUNT_BITS;
   localparam int RANDOM_ITEMS = 300;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;
   localparam logic signed [KEY_PORT_BITS-1:0] KEY_MIN = 32'sh8000_0000;
   localparam logic signed [KEY_PORT_BITS-1:0] KEY_MAX = 32'sh7FFF_FFFF;

   typedef struct packed {
      logic                 found;
      logic [SLOT_BITS-1:0] position;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [CMD_BITS-1:0] req_command = CMD_UNUSED;
   logic [SLOT_BITS-1:0] req_slot = '0;
   logic signed [KEY_PORT_BITS-1:0] req_key = '0;
   logic [SLOT_BITS-1:0] req_block_start = '0;
   logic [SLOT_BITS-1:0] req_block_end = '0;
   logic rsp_valid;
   logic rsp_found;
   logic [SLOT_BITS-1:0] rsp_position;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [COUNT_BITS-1:0] csr_block_count = bis_pkg::COUNT_RESET;

   // predictor state
   logic signed [KEY_PORT_BITS-1:0] record_key_store [RECORDS];
   logic signed [KEY_PORT_BITS-1:0] index_max_key [BLOCKS];
   logic [SLOT_BITS-1:0] index_first [BLOCKS];
   logic [SLOT_BITS-1:0] index_last [BLOCKS];
   logic [COUNT_BITS-1:0] blocks_in_use = bis_pkg::COUNT_RESET;

   lookup_result_type pending_lookups [$];

   int error_count = 0;
   int cycle_count = 0;
   int items_applied = 0;
   int searches_sent = 0;
   int hits_seen = 0;
   int store_writes = 0;
   int count_settings = 0;
   bit fast_sender = 1'b0;

   block_indexed_search DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_slot        (req_slot),
      .req_key         (req_key),
      .req_block_start (req_block_start),
      .req_block_end   (req_block_end),
      .rsp_valid       (rsp_valid),
      .rsp_found       (rsp_found),
      .rsp_position    (rsp_position),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_block_count (csr_block_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic report_mismatch(input string what);
      error_count++;
      if (error_count <= 100) $display("mismatch at %0t: %s", $time, what);
   endtask

   // binary search of the index, then an in-order scan of the chosen block
   function automatic lookup_result_type search_index(
      input logic signed [KEY_PORT_BITS-1:0] key);
      lookup_result_type res;
      int n;
      int lo;
      int hi;
      int mid;
      int blk;
      int p;
      bit stop;
      res = '0;
      n = (int'(blocks_in_use) > BLOCKS) ? BLOCKS : int'(blocks_in_use);
      lo = 0;
      hi = n - 1;
      stop = 1'b0;
      while (lo <= hi && !stop) begin
         mid = (lo + hi) / 2;
         if (key < index_max_key[mid]) begin
            hi = mid - 1;
         end else if (key > index_max_key[mid]) begin
            lo = mid + 1;
         end else begin
            hi = mid - 1;
            stop = 1'b1;
         end
      end
      blk = hi + 1;
      if (blk < n) begin
         p = int'(index_first[blk]);
         while (p <= int'(index_last[blk]) && !res.found) begin
            if (p < RECORDS && record_key_store[p] == key) begin
               res.found = 1'b1;
               res.position = SLOT_BITS'(p);
            end
            p++;
         end
      end
      return res;
   endfunction

   function automatic void apply_item(input logic [CMD_BITS-1:0] cmd,
                                      input logic [SLOT_BITS-1:0] slot,
                                      input logic signed [KEY_PORT_BITS-1:0] key,
                                      input logic [SLOT_BITS-1:0] blk_first,
                                      input logic [SLOT_BITS-1:0] blk_last);
      case (cmd)
         bis_pkg::CMD_WRITE_RECORD: begin
            if (int'(slot) < RECORDS) begin
               record_key_store[slot] = key;
               store_writes++;
               items_applied++;
            end
         end
         bis_pkg::CMD_WRITE_INDEX: begin
            if (int'(slot) < BLOCKS) begin
               index_max_key[slot] = key;
               index_first[slot] = blk_first;
               index_last[slot] = blk_last;
               store_writes++;
               items_applied++;
            end
         end
         bis_pkg::CMD_SEARCH: begin
            pending_lookups.push_back(search_index(key));
            searches_sent++;
            items_applied++;
         end
         default: begin
         end
      endcase
   endfunction

   task automatic send_item(input logic [CMD_BITS-1:0] cmd,
                            input logic [SLOT_BITS-1:0] slot,
                            input logic signed [KEY_PORT_BITS-1:0] key,
                            input logic [SLOT_BITS-1:0] blk_first,
                            input logic [SLOT_BITS-1:0] blk_last);
      int gap;
      gap = fast_sender ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_slot <= slot;
      req_key <= key;
      req_block_start <= blk_first;
      req_block_end <= blk_last;
      do @(posedge clock); while (busy);
      apply_item(cmd, slot, key, blk_first, blk_last);
   endtask

   task automatic search_for(input logic signed [KEY_PORT_BITS-1:0] key);
      send_item(bis_pkg::CMD_SEARCH, SLOT_BITS'($urandom()), key, SLOT_BITS'($urandom()),
                SLOT_BITS'($urandom()));
   endtask

   task automatic wait_all_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_lookups.size() != 0);
   endtask

   task automatic write_block_count(input logic [COUNT_BITS-1:0] value);
      wait_all_results();
      // writes leave no beat behind, so give the last one time to land
      repeat (8) @(posedge clock);
      csr_valid <= 1'b1;
      csr_block_count <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      blocks_in_use = value;
      count_settings++;
   endtask

   // non-decreasing keys split into consecutive blocks, each indexed by its last key
   task automatic build_index(input int nblocks, input int maxlen, output int used);
      longint acc;
      int pos;
      int len;
      int r;
      acc = longint'($urandom_range(0, 32'hBFFF_FFFF)) - 64'sd2147483648;
      pos = 0;
      for (int b = 0; b < nblocks; b++) begin
         len = $urandom_range(1, maxlen);
         for (int i = 0; i < len; i++) begin
            if (pos + i > 0) begin
               r = $urandom_range(0, 9);
               if (r == 0) acc = acc;
               else if (r < 5) acc = acc + $urandom_range(1, 3);
               else acc = acc + $urandom_range(1, 1 << 23);
            end
            send_item(bis_pkg::CMD_WRITE_RECORD, SLOT_BITS'(pos + i), acc[31:0],
                      SLOT_BITS'($urandom()), SLOT_BITS'($urandom()));
         end
         send_item(bis_pkg::CMD_WRITE_INDEX, SLOT_BITS'(b), acc[31:0], SLOT_BITS'(pos),
                   SLOT_BITS'(pos + len - 1));
         pos += len;
      end
      used = pos;
   endtask

   function automatic logic signed [KEY_PORT_BITS-1:0] pick_search_key(
      input int used, input int nblocks);
      logic signed [KEY_PORT_BITS-1:0] k;
      int r;
      r = $urandom_range(0, 9);
      k = record_key_store[$urandom_range(0, used - 1)];
      if (r == 5) k = k + 1;
      else if (r == 6) k = k - 1;
      else if (r == 7) k = index_max_key[$urandom_range(0, nblocks - 1)];
      else if (r == 8) k = $urandom();
      else if (r == 9) k = $urandom_range(0, 1) ? KEY_MIN : KEY_MAX;
      return k;
   endfunction

   // every entry gets written so that no search reads an unwritten one
   task automatic test_fill_stores();
      for (int p = 0; p < RECORDS; p++)
         send_item(bis_pkg::CMD_WRITE_RECORD, SLOT_BITS'(p), $urandom(), '0, '0);
      for (int b = 0; b < BLOCKS; b++)
         send_item(bis_pkg::CMD_WRITE_INDEX, SLOT_BITS'(b), $urandom(),
                   SLOT_BITS'($urandom()), SLOT_BITS'($urandom()));
   endtask

   task automatic test_directed_cases();
      write_block_count(COUNT_BITS'(2));
      send_item(bis_pkg::CMD_WRITE_RECORD, 7'd0, KEY_MIN, '0, '0);
      send_item(bis_pkg::CMD_WRITE_RECORD, 7'd1, -32'sd5, '0, '0);
      send_item(bis_pkg::CMD_WRITE_RECORD, 7'd2, 32'sd7, '0, '0);
      send_item(bis_pkg::CMD_WRITE_RECORD, 7'd3, KEY_MAX, '0, '0);
      send_item(bis_pkg::CMD_WRITE_INDEX, 7'd0, -32'sd5, 7'd0, 7'd1);
      send_item(bis_pkg::CMD_WRITE_INDEX, 7'd1, KEY_MAX, 7'd2, 7'd3);
      search_for(KEY_MIN);
      // exact hits on index maxima, then a hit inside a block and a miss
      search_for(-32'sd5);
      search_for(KEY_MAX);
      search_for(32'sd7);
      search_for(32'sd0);
      // index slots past the table and the unused command are dropped
      send_item(bis_pkg::CMD_WRITE_INDEX, 7'd127, 32'sd0, 7'd127, 7'd127);
      send_item(bis_pkg::CMD_WRITE_INDEX, 7'd32, 32'sd0, 7'd0, 7'd0);
      send_item(CMD_UNUSED, 7'd127, KEY_MAX, 7'd127, 7'd127);
      search_for(32'sd7);
      // empty block
      send_item(bis_pkg::CMD_WRITE_INDEX, 7'd1, KEY_MAX, 7'd3, 7'd2);
      search_for(32'sd7);
      // key above every block maximum
      send_item(bis_pkg::CMD_WRITE_INDEX, 7'd1, 32'sd7, 7'd2, 7'd3);
      search_for(KEY_MAX);
      search_for(32'sd8);
      // widest block
      send_item(bis_pkg::CMD_WRITE_INDEX, 7'd1, 32'sd7, 7'd0, 7'd127);
      search_for(32'sd7);
      write_block_count(COUNT_BITS'(0));
      search_for(-32'sd5);
      write_block_count(COUNT_BITS'(63));
      search_for(-32'sd5);
      search_for(32'sd7);
   endtask

   task automatic test_random_traffic();
      int phase;
      int nblocks;
      int maxlen;
      int used;
      int ops;
      int r;
      int base_items;
      logic [COUNT_BITS-1:0] count_value;
      phase = 0;
      base_items = items_applied;
      while (items_applied - base_items < RANDOM_ITEMS || phase < 6) begin
         case (phase % 6)
            0: count_value = COUNT_BITS'(1);
            1: count_value = COUNT_BITS'(BLOCKS);
            2: count_value = COUNT_BITS'(0);
            3: count_value = COUNT_BITS'(63);
            default: count_value = COUNT_BITS'($urandom_range(2, BLOCKS - 1));
         endcase
         if (count_value == 0) nblocks = $urandom_range(1, 8);
         else if (int'(count_value) > BLOCKS) nblocks = BLOCKS;
         else nblocks = int'(count_value);
         maxlen = RECORDS / nblocks;
         if (maxlen > 4) maxlen = $urandom_range(2, 4);
         write_block_count(count_value);
         fast_sender = (phase % 3 == 1);
         build_index(nblocks, maxlen, used);
         ops = $urandom_range(12, 24);
         for (int i = 0; i < ops; i++) begin
            if (i == ops / 2) wait_all_results();
            r = $urandom_range(0, 9);
            if (r < 8) begin
               search_for(pick_search_key(used, nblocks));
            end else begin
               r = $urandom_range(0, 3);
               if (r < 2)
                  send_item(bis_pkg::CMD_WRITE_RECORD, SLOT_BITS'($urandom()), $urandom(),
                            SLOT_BITS'($urandom()), SLOT_BITS'($urandom()));
               else if (r == 2)
                  send_item(bis_pkg::CMD_WRITE_INDEX, SLOT_BITS'($urandom()), $urandom(),
                            SLOT_BITS'($urandom()), SLOT_BITS'($urandom()));
               else
                  send_item(CMD_UNUSED, SLOT_BITS'($urandom()), $urandom(),
                            SLOT_BITS'($urandom()), SLOT_BITS'($urandom()));
            end
         end
         phase++;
      end
      fast_sender = 1'b0;
   endtask

   always @(posedge clock) begin : check_results
      lookup_result_type want;
      if (!reset && rsp_valid) begin
         if (pending_lookups.size() == 0) begin
            report_mismatch("result beat with no search outstanding");
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_found !== want.found)
               report_mismatch($sformatf("found %b, wanted %b", rsp_found, want.found));
            if (rsp_position !== want.position)
               report_mismatch($sformatf("position %0d, wanted %0d", rsp_position,
                                         want.position));
            if (rsp_found === 1'b1) hits_seen++;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("testbench: done, errors");
      $finish;
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_stores();
      test_directed_cases();
      test_random_traffic();
      wait_all_results();
      repeat (20) @(posedge clock);
      $display("testbench: %0d searches (%0d hits), %0d store writes", searches_sent,
               hits_seen, store_writes);
      $display("testbench: %0d block count settings, including 0, 1, 32 and 63",
               count_settings);
      if (error_count == 0) begin
         $display("testbench: done, clean");
      end else begin
         $display("testbench: done, errors");
      end
      $finish;
   end
endmodule

/* sim.f */
hdl/bis_pkg.sv
hdl/bis_ram.sv
hdl/bis_ctrl.sv
hdl/bis_dpath.sv
hdl/block_indexed_search.sv
hdl/bis_check.sv
dv/testbench.sv
